/* src/dgps_pkg.sv */
package dgps_pkg;

  typedef struct packed {
    logic       accepted;
    logic [7:0] pin_byte;
  } in_t;

  typedef struct packed {
    logic       drive_valid;
    logic [7:0] drive_byte;
    logic [7:0] joystick;
  } out_t;

  typedef enum logic {
    MODE_SERIAL = 1'b0,
    MODE_MUX    = 1'b1
  } mode_t;

  localparam int PHASE_W = 6;

  localparam logic signed [PHASE_W-1:0] PHASE_START = -6'sd6;
  localparam logic signed [PHASE_W-1:0] PHASE_MIN   = -6'sd7;
  localparam logic signed [PHASE_W-1:0] PHASE_MAX   = 6'sd23;

  localparam logic [7:0] LATCH_BIT  = 8'h04;
  localparam logic [7:0] CLOCK_BIT  = 8'h08;
  localparam logic [7:0] SELECT_BIT = 8'h40;
  localparam logic [7:0] FIRST_MASK = 8'h80;
  localparam logic [7:0] DRIVE_IDLE = 8'hFF;
  localparam logic [7:0] DIR_MASK   = 8'h3F;
  localparam logic [7:0] LR_MASK    = 8'h0C;

  localparam int DATA_POS = 1;

  function automatic logic [7:0] remap_serial(input logic [7:0] b);
    return ~{b[4], b[5], b[7:6], b[3:0]};
  endfunction

  function automatic logic [7:0] remap_mux(input logic [7:0] s);
    return ~{s[7], s[5], s[6], s[4], s[0], s[1], s[2], s[3]};
  endfunction

endpackage

/* src/dual_gamepad_port_scanner.sv */
// The result of each accepted request is written into the output register.
// Throughput: one request per cycle; in_ready stays high unless the held result is stalled.
// Each request computes the next phase state and the result with combinational logic.
// Reset (rst, synchronous, active high): phase -6, multiplexed phase, drive 0xFF,
// collected bytes and joystick cleared, output register empty.
module dual_gamepad_port_scanner (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dgps_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dgps_pkg::out_t out_data
);

  logic signed [dgps_pkg::PHASE_W-1:0] phase, phase_next;
  dgps_pkg::mode_t pad_mode, pad_mode_next;
  logic [7:0] bit_mask, bit_mask_next;
  logic [7:0] serial_pad_bits, serial_pad_bits_next;
  logic [7:0] mux_pad_bits, mux_pad_bits_next;
  logic [7:0] drive_latch, drive_latch_next;
  logic [7:0] joystick_state, joystick_state_next;
  logic       dv;
  logic       in_fire;
  logic       ok;
  logic [7:0] pins;
  dgps_pkg::out_t res;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign ok       = in_data.accepted;
  assign pins     = in_data.pin_byte;

  always_comb begin
    phase_next           = phase + 6'sd1;
    pad_mode_next        = pad_mode;
    bit_mask_next        = bit_mask;
    serial_pad_bits_next = serial_pad_bits;
    mux_pad_bits_next    = mux_pad_bits;
    drive_latch_next     = drive_latch;
    joystick_state_next  = joystick_state;
    dv                   = 1'b0;
    if (pad_mode == dgps_pkg::MODE_SERIAL) begin
      if (phase_next >= 6'sd0) begin
        if (phase_next == 6'sd0) begin
          bit_mask_next    = dgps_pkg::FIRST_MASK;
          drive_latch_next = drive_latch & ~dgps_pkg::LATCH_BIT;
        end else if (phase_next >= 6'sd4 && phase_next <= 6'sd19) begin
          if (phase_next[0]) begin
            drive_latch_next = drive_latch | dgps_pkg::CLOCK_BIT;
          end else begin
            drive_latch_next = drive_latch & ~dgps_pkg::CLOCK_BIT;
          end
        end else if (phase_next == 6'sd20) begin
          bit_mask_next = '0;
        end else if (phase_next == 6'sd22) begin
          drive_latch_next = drive_latch | dgps_pkg::LATCH_BIT;
        end else if (phase_next == dgps_pkg::PHASE_MAX) begin
          phase_next    = dgps_pkg::PHASE_START;
          pad_mode_next = dgps_pkg::MODE_MUX;
        end
        dv = 1'b1;
        if (!ok) begin
          phase_next = phase_next - 6'sd1;
        end else if (phase_next > 6'sd3 && phase_next < 6'sd20 && phase_next[0]) begin
          if (pins[dgps_pkg::DATA_POS]) begin
            serial_pad_bits_next = serial_pad_bits | bit_mask_next;
          end
          bit_mask_next = bit_mask_next >> 1;
        end
      end
    end else begin
      if (phase_next < 6'sd0) begin
        drive_latch_next = dgps_pkg::DRIVE_IDLE;
      end
      if (phase_next == 6'sd0) begin
        drive_latch_next = dgps_pkg::DRIVE_IDLE & ~dgps_pkg::SELECT_BIT;
      end else if (phase_next == 6'sd5) begin
        phase_next           = dgps_pkg::PHASE_START;
        mux_pad_bits_next    = '0;
        serial_pad_bits_next = '0;
        pad_mode_next        = dgps_pkg::MODE_SERIAL;
      end
      dv = 1'b1;
      if (!ok) begin
        phase_next = phase_next - 6'sd1;
      end else begin
        if (phase_next == 6'sd0) begin
          mux_pad_bits_next = mux_pad_bits | (pins & dgps_pkg::DIR_MASK);
        end
        if (phase_next == 6'sd4) begin
          mux_pad_bits_next = mux_pad_bits | {pins[5:4], 6'b0};
          if ((pins & dgps_pkg::LR_MASK) == 8'h00) begin
            joystick_state_next = dgps_pkg::remap_mux(mux_pad_bits_next);
          end else begin
            joystick_state_next = dgps_pkg::remap_serial(serial_pad_bits);
          end
        end
      end
    end
    res.drive_valid = dv;
    res.drive_byte  = dv ? drive_latch_next : 8'h00;
    res.joystick    = joystick_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= dgps_pkg::PHASE_START;
      pad_mode        <= dgps_pkg::MODE_MUX;
      bit_mask        <= '0;
      serial_pad_bits <= '0;
      mux_pad_bits    <= '0;
      drive_latch     <= dgps_pkg::DRIVE_IDLE;
      joystick_state  <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (in_fire) begin
        phase           <= phase_next;
        pad_mode        <= pad_mode_next;
        bit_mask        <= bit_mask_next;
        serial_pad_bits <= serial_pad_bits_next;
        mux_pad_bits    <= mux_pad_bits_next;
        drive_latch     <= drive_latch_next;
        joystick_state  <= joystick_state_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res;
    end
  end

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted request produced no result");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase >= dgps_pkg::PHASE_MIN && phase <= dgps_pkg::PHASE_MAX)
    else $error("phase counter out of range");

  a_mask_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bit_mask) && (pad_mode != dgps_pkg::MODE_MUX || bit_mask == 8'h00))
    else $error("serial bit selector corrupt");

  a_select_low_serial: assert property (@(posedge clk) disable iff (rst)
    pad_mode == dgps_pkg::MODE_SERIAL |-> !drive_latch[6])
    else $error("select not held low during serial phase");

endmodule
